// ===== src/physical_page_allocator_unit_macros.svh =====
// Assertion macros for the page allocator RTL
`ifndef PHYSICAL_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`define PHYSICAL_PAGE_ALLOCATOR_UNIT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define PPA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define PPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ppa_pkg.sv =====
// Shared types and constants of the physical page allocator
`timescale 1ns / 1ps
`default_nettype none
package ppa_pkg;

    localparam int MAX_RANGES   = 32;
    localparam int PAGE_BYTES   = 4096;
    localparam int STACK_DEPTH  = 1024;
    localparam int ADDR_BITS    = 64;

    localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
    localparam int PN_BITS      = ADDR_BITS - PAGE_SHIFT;
    localparam int RIDX_BITS    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int RCNT_BITS    = $clog2(MAX_RANGES + 1);
    localparam int SIDX_BITS    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCNT_BITS    = $clog2(STACK_DEPTH + 1);
    localparam int COUNT_BITS   = 53;
    localparam int FUNC_BITS    = 2;
    localparam int TYPE_BITS    = 32;
    localparam int STATUS_BITS  = 3;
    localparam int TYPE_AVAILABLE = 1;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_CLEAR  = 2'd0,
        FN_REGION = 2'd1,
        FN_ALLOC  = 2'd2,
        FN_FREE   = 2'd3
    } t_func;

    typedef enum logic [STATUS_BITS-1:0] {
        STS_OK         = 3'd0,
        STS_OOM        = 3'd1,
        STS_FORCED     = 3'd2,
        STS_MISALIGNED = 3'd3,
        STS_STACK_FULL = 3'd4,
        STS_SKIPPED    = 3'd5
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic stage_a;
        logic stage_b;
        logic commit;
    } t_ppa_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_region;
        logic out_free;
    } t_ppa_sts;

endpackage
`default_nettype wire

// ===== src/physical_page_allocator_unit.sv =====
// Top level of the physical page allocator
`timescale 1ns / 1ps
`default_nettype none
// Physical page allocator. One request beat in, one result beat out. A region
// request runs its alignment and clipping arithmetic (stage A, then stage B)
// before the commit; clear, allocate and free commit from the execute state,
// after the registered stack and range table memory reads. One request
// is in flight at a time; a finished result waits in the output register while
// the next request is taken, and the commit of that next request holds until
// the waiting result beat is taken. Allocation pops the recycled stack first,
// then bumps the first range that still has pages. Registers: kernel end
// address at 0x0, fail_after at 0x8 (writing it reloads the countdown).
`include "physical_page_allocator_unit_macros.svh"
module physical_page_allocator_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    // region_base[63:0], region_length[127:64], region_type[159:128],
    // free_address[223:160]
    input  wire [223:0]  s_tdata,
    // func[1:0]
    input  wire [1:0]    s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // status[2:0], page_address[66:3], free_count[119:67]
    output logic [119:0] m_tdata,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire [3:0]    paddr,
    input  wire [63:0]   pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    ppa_pkg::t_ppa_cmd cmd;
    ppa_pkg::t_ppa_sts sts;
    logic        cfg_wr;
    logic [63:0] kend_q, fail_q;
    logic [2:0]  out_status;
    logic [63:0] out_page;
    logic [52:0] out_free;

    // Decode register writes
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[3] ? fail_q : kend_q;

    ppa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ppa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_func          (s_tuser),
        .i_region_base   (s_tdata[63:0]),
        .i_region_length (s_tdata[127:64]),
        .i_region_type   (s_tdata[159:128]),
        .i_free_address  (s_tdata[223:160]),
        .i_cfg_we_kend   (cfg_wr && !paddr[3]),
        .i_cfg_we_fail   (cfg_wr && paddr[3]),
        .i_cfg_wdata     (pwdata),
        .o_kend_value    (kend_q),
        .o_fail_after    (fail_q),
        .o_out_valid     (m_tvalid),
        .i_out_ready     (m_tready),
        .o_status        (out_status),
        .o_page_address  (out_page),
        .o_free_count    (out_free)
    );

    assign m_tdata = {out_free, out_page, out_status};

    // One request at a time
    `PPA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second beat while busy")
    // Failed or non-allocating results carry no page
    `PPA_ASSERT_SAME(a_page_zero, m_tvalid && (out_status != ppa_pkg::STS_OK), out_page == '0, "page on failure")
    // Handed-out pages are aligned
    `PPA_ASSERT_SAME(a_page_align, m_tvalid, out_page[ppa_pkg::PAGE_SHIFT-1:0] == '0, "unaligned page")

endmodule
`default_nettype wire

// ===== src/ppa_ctrl.sv =====
// Sequencing state machine of the page allocator
`timescale 1ns / 1ps
`default_nettype none
module ppa_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  ppa_pkg::t_ppa_sts  i_sts,
    output ppa_pkg::t_ppa_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_CLIP = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_region) begin
                    o_cmd.stage_a = 1'b1;
                    n_state       = S_CLIP;
                end else if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_CLIP: begin
                o_cmd.stage_b = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== src/ppa_dp.sv =====
// Datapath of the page allocator: range table, recycled stack, counters
`timescale 1ns / 1ps
`default_nettype none
module ppa_dp (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  ppa_pkg::t_ppa_cmd                     i_cmd,
    output ppa_pkg::t_ppa_sts                     o_sts,
    input  wire [ppa_pkg::FUNC_BITS-1:0]          i_func,
    input  wire [ppa_pkg::ADDR_BITS-1:0]          i_region_base,
    input  wire [63:0]                            i_region_length,
    input  wire [ppa_pkg::TYPE_BITS-1:0]          i_region_type,
    input  wire [ppa_pkg::ADDR_BITS-1:0]          i_free_address,
    input  wire                                   i_cfg_we_kend,
    input  wire                                   i_cfg_we_fail,
    input  wire [63:0]                            i_cfg_wdata,
    output logic [63:0]                           o_kend_value,
    output logic [63:0]                           o_fail_after,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic [ppa_pkg::STATUS_BITS-1:0]       o_status,
    output logic [ppa_pkg::ADDR_BITS-1:0]         o_page_address,
    output logic [ppa_pkg::COUNT_BITS-1:0]        o_free_count
);

    localparam int AW = ppa_pkg::ADDR_BITS;
    localparam int PS = ppa_pkg::PAGE_SHIFT;
    localparam int PN = ppa_pkg::PN_BITS;
    localparam int CB = ppa_pkg::COUNT_BITS;
    localparam int RI = ppa_pkg::RIDX_BITS;
    localparam int RC = ppa_pkg::RCNT_BITS;
    localparam int SI = ppa_pkg::SIDX_BITS;
    localparam int SC = ppa_pkg::SCNT_BITS;
    localparam int NR = ppa_pkg::MAX_RANGES;
    localparam logic [63:0] AMASK = 64'({AW{1'b1}});

    // Saturating count add
    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a,
                                              input logic [PN-1:0] b);
        logic [CB:0] s;
        s = {1'b0, a} + (CB+1)'(b);
        sat_add = s[CB] ? '1 : s[CB-1:0];
    endfunction

    // Align up to a page; flag overflow past the address space
    function automatic logic [AW:0] page_ceil(input logic [AW-1:0] v);
        logic [AW:0] r;
        if (v[PS-1:0] == '0) begin
            r = {1'b0, v};
        end else if (&v[AW-1:PS]) begin
            r = {1'b1, v};
        end else begin
            r = {1'b0, v[AW-1:PS] + PN'(1), {PS{1'b0}}};
        end
        page_ceil = r;
    endfunction

    // Item registers
    logic [ppa_pkg::FUNC_BITS-1:0] r_func;
    logic [AW-1:0]                 r_base;
    logic [63:0]                   r_len;
    logic                          r_type_ok;
    logic [AW-1:0]                 r_faddr;

    // Configuration and control state
    logic [63:0]  r_kend_cfg, r_fail_after, r_countdown, n_countdown;
    logic [RC-1:0] r_used, n_used;
    logic [CB-1:0] r_total, n_total;
    logic [SC-1:0] r_top, n_top;
    logic [NR-1:0] r_live, n_live;

    // Region pipeline
    logic [AW-1:0] r_end, r_start, r_kend;
    logic          r_start_ovf, r_kend_ovf;
    logic [AW-1:0] r_startc;
    logic          r_skip;
    logic [PN-1:0] r_pages;

    // Memories
    logic [AW-1:0] range_next_mem  [NR];
    logic [AW-1:0] range_limit_mem [NR];
    logic [PN-1:0] stack_mem       [ppa_pkg::STACK_DEPTH];
    logic [AW-1:0] r_rd_next, r_rd_limit;
    logic [PN-1:0] r_rd_stack;

    // Output register
    logic                           r_out_valid;
    logic [ppa_pkg::STATUS_BITS-1:0] r_status, n_status;
    logic [AW-1:0]                  r_page, n_page;
    logic [CB-1:0]                  r_free;

    // Write controls
    logic          rng_we, lim_we, stk_we;
    logic [RI-1:0] rng_widx;
    logic [AW-1:0] rng_wnext;

    // Stage A combinational
    logic [AW:0]   sum_top;
    logic [AW-1:0] top_sat;
    logic [AW:0]   start_c, kend_c;

    // Pick the first range that still has pages
    logic [RI-1:0] sel_idx;
    logic          sel_any;
    always_comb begin
        sel_idx = '0;
        sel_any = |r_live;
        for (int i = NR - 1; i >= 0; i--) begin
            if (r_live[i]) begin
                sel_idx = RI'(i);
            end
        end
    end

    logic [SC-1:0] top_m1;
    logic [AW-1:0] bump_next;
    assign top_m1    = r_top - SC'(1);
    assign bump_next = r_rd_next + AW'(ppa_pkg::PAGE_BYTES);

    // Memory ports
    always_ff @(posedge i_clk) begin
        r_rd_next  <= range_next_mem[sel_idx];
        r_rd_limit <= range_limit_mem[sel_idx];
        r_rd_stack <= stack_mem[top_m1[SI-1:0]];
        if (rng_we) begin
            range_next_mem[rng_widx] <= rng_wnext;
        end
        if (lim_we) begin
            range_limit_mem[rng_widx] <= r_end;
        end
        if (stk_we) begin
            stack_mem[r_top[SI-1:0]] <= r_faddr[AW-1:PS];
        end
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_base    <= i_region_base;
            r_len     <= i_region_length;
            r_type_ok <= (i_region_type == ppa_pkg::TYPE_BITS'(ppa_pkg::TYPE_AVAILABLE));
            r_faddr   <= i_free_address;
        end
    end

    // Region stage A: end, aligned start, aligned kernel end
    assign sum_top = {1'b0, r_base} + {1'b0, r_len[AW-1:0]};
    assign top_sat = (sum_top[AW] || (r_len > AMASK)) ? '1 : sum_top[AW-1:0];
    assign start_c = page_ceil(r_base);
    assign kend_c  = page_ceil(r_kend_cfg[AW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.stage_a) begin
            r_end       <= {top_sat[AW-1:PS], {PS{1'b0}}};
            r_start     <= start_c[AW-1:0];
            r_start_ovf <= start_c[AW];
            r_kend      <= kend_c[AW-1:0];
            r_kend_ovf  <= kend_c[AW] || (r_kend_cfg > AMASK);
        end
    end

    // Region stage B: clip to kernel end, decide, size
    logic [AW-1:0] startc_b;
    assign startc_b = (r_start < r_kend) ? r_kend : r_start;
    always_ff @(posedge i_clk) begin
        if (i_cmd.stage_b) begin
            r_startc <= startc_b;
            r_skip   <= !r_type_ok || r_kend_ovf || r_start_ovf || (startc_b >= r_end)
                        || (r_used >= RC'(NR));
            r_pages  <= PN'((r_end - startc_b) >> PS);
        end
    end

    // Commit one item
    always_comb begin
        n_countdown = r_countdown;
        n_used      = r_used;
        n_total     = r_total;
        n_top       = r_top;
        n_live      = r_live;
        n_status    = ppa_pkg::STS_OK;
        n_page      = '0;
        rng_we      = 1'b0;
        lim_we      = 1'b0;
        stk_we      = 1'b0;
        rng_widx    = sel_idx;
        rng_wnext   = bump_next;
        case (r_func)
            ppa_pkg::FN_CLEAR: begin
                n_used  = '0;
                n_total = '0;
                n_top   = '0;
                n_live  = '0;
            end
            ppa_pkg::FN_REGION: begin
                if (r_skip) begin
                    n_status = ppa_pkg::STS_SKIPPED;
                end else begin
                    rng_we    = i_cmd.commit;
                    lim_we    = i_cmd.commit;
                    rng_widx  = r_used[RI-1:0];
                    rng_wnext = r_startc;
                    n_live[r_used[RI-1:0]] = 1'b1;
                    n_used    = r_used + RC'(1);
                    n_total   = sat_add(r_total, r_pages);
                end
            end
            ppa_pkg::FN_ALLOC: begin
                if (r_countdown == '0) begin
                    n_status = ppa_pkg::STS_FORCED;
                end else begin
                    if (r_countdown != '1) begin
                        n_countdown = r_countdown - 64'd1;
                    end
                    if (r_top != '0) begin
                        n_top   = top_m1;
                        n_page  = {r_rd_stack, {PS{1'b0}}};
                        n_total = (r_total != '0) ? r_total - CB'(1) : r_total;
                    end else if (sel_any) begin
                        n_page  = r_rd_next;
                        rng_we  = i_cmd.commit;
                        if (bump_next == r_rd_limit) begin
                            n_live[sel_idx] = 1'b0;
                        end
                        n_total = (r_total != '0) ? r_total - CB'(1) : r_total;
                    end else begin
                        n_status = ppa_pkg::STS_OOM;
                    end
                end
            end
            ppa_pkg::FN_FREE: begin
                if (r_faddr[PS-1:0] != '0) begin
                    n_status = ppa_pkg::STS_MISALIGNED;
                end else if (r_top >= SC'(ppa_pkg::STACK_DEPTH)) begin
                    n_status = ppa_pkg::STS_STACK_FULL;
                end else begin
                    stk_we  = i_cmd.commit;
                    n_top   = r_top + SC'(1);
                    n_total = sat_add(r_total, PN'(1));
                end
            end
            default: n_status = ppa_pkg::STS_OK;
        endcase
    end

    // Control state, configuration and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kend_cfg   <= '0;
            r_fail_after <= '1;
            r_countdown  <= '1;
            r_used       <= '0;
            r_total      <= '0;
            r_top        <= '0;
            r_live       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we_kend) begin
                r_kend_cfg <= i_cfg_wdata;
            end
            if (i_cfg_we_fail) begin
                r_fail_after <= i_cfg_wdata;
                r_countdown  <= i_cfg_wdata;
            end else if (i_cmd.commit) begin
                r_countdown <= n_countdown;
            end
            if (i_cmd.commit) begin
                r_used      <= n_used;
                r_total     <= n_total;
                r_top       <= n_top;
                r_live      <= n_live;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_page   <= n_page;
            r_free   <= n_total;
        end
    end

    assign o_sts.is_region = (r_func == ppa_pkg::FN_REGION);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_kend_value    = r_kend_cfg;
    assign o_fail_after    = r_fail_after;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_page_address  = r_page;
    assign o_free_count    = r_free;

endmodule
`default_nettype wire
